// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks on clk with reset held off, for files that assert.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- hdl/itda_pkg.sv -----
// ----------------------------------------------------------------------------
// itda_pkg
// Types, widths and codes for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package itda_pkg;

  localparam int VALUE_W    = 64;
  localparam int HALF_W     = 32;
  localparam int CMD_W      = 2;
  localparam int CHAR_W     = 6;
  localparam int LEN_W      = 5;
  localparam int DIG_W      = 4;
  localparam int NUM_DIGITS = 20;
  localparam int IDX_W      = $clog2(NUM_DIGITS);
  localparam int ITER_W     = $clog2(VALUE_W + 1);
  localparam int MAX_CHARS  = 20;

  localparam logic [CMD_W-1:0]  CMD_S32 = 2'd0;
  localparam logic [CMD_W-1:0]  CMD_U32 = 2'd1;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

  typedef logic [NUM_DIGITS-1:0][DIG_W-1:0] bcd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIZE,
    ST_EMIT
  } state_t;

endpackage

// ----- hdl/itda_bcd_unit.sv -----
// ----------------------------------------------------------------------------
// itda_bcd_unit
// One shift-add-3 step: adjust every BCD digit, then shift in one binary bit.
// ----------------------------------------------------------------------------
module itda_bcd_unit
  import itda_pkg::*;
(
  input  bcd_t bcd_i,
  input  logic bit_i,
  output bcd_t bcd_o
);

  bcd_t adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      adj[i] = (bcd_i[i] >= DIG_W'(5)) ? bcd_i[i] + DIG_W'(3) : bcd_i[i];
    end
  end

  // shift the whole BCD word left, binary bit enters digit zero
  assign bcd_o = bcd_t'({adj, bit_i});

endmodule

// ----- hdl/int_to_decimal_ascii_core.sv -----
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core
// Binary integer to decimal ASCII text, one character per output transaction.
//
//   channel | dir | tdata                              | tuser         | tlast
//   in_     | in  | [63:0] value                       | [1:0] command | -
//   out_    | out | [5:0] character, [10:6] text_length | -             | last
//
// One transaction in, then one shift-add-3 step per bit of the magnitude (the
// low half for 32-bit commands, all 64 bits otherwise) through the shared BCD
// adjust unit, a sizing state, then the characters while out_tready is high.
// in_tready is high only between numbers. A stall on out_ holds the current
// character. Synchronous active-low reset returns the sequencer to idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module int_to_decimal_ascii_core
  import itda_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // [63:0] value
  input  logic [1:0]   in_tuser,   // [1:0] command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,  // [5:0] character, [10:6] text_length, zero pad
  output logic         out_tlast
);

  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_CHARS);

  state_t state_r, state_nxt;

  logic [VALUE_W-1:0] mag_r;
  logic [ITER_W-1:0]  iter_r;
  logic               neg_r;
  bcd_t               bcd_r;
  bcd_t               bcd_step;
  logic [LEN_W-1:0]   tot_r;
  logic [LEN_W-1:0]   cnt_r;
  logic [LEN_W-1:0]   pos_r;

  logic               do_load;
  logic               do_conv;
  logic               do_size;
  logic               do_adv;
  logic               last_c;

  logic [HALF_W-1:0]  low_c;
  logic [LEN_W-1:0]   nd_c;
  logic [LEN_W-1:0]   tot_c;
  logic [LEN_W-1:0]   cnt_c;
  logic [IDX_W-1:0]   dig_idx;
  logic [CHAR_W-1:0]  char_c;

  itda_bcd_unit u_bcd (
    .bcd_i (bcd_r),
    .bit_i (mag_r[VALUE_W-1]),
    .bcd_o (bcd_step)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_CONV;
      ST_CONV: if (iter_r == ITER_W'(1)) state_nxt = ST_SIZE;
      ST_SIZE: state_nxt = ST_EMIT;
      ST_EMIT: if (out_tready && last_c) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    do_conv    = 1'b0;
    do_size    = 1'b0;
    unique case (state_r)
      ST_IDLE: in_tready  = 1'b1;
      ST_CONV: do_conv    = 1'b1;
      ST_SIZE: do_size    = 1'b1;
      ST_EMIT: out_tvalid = 1'b1;
      default: in_tready  = 1'b0;
    endcase
  end

  assign do_load = in_tvalid && in_tready;
  assign do_adv  = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------- datapath ----------------
  assign low_c = in_tdata[HALF_W-1:0];

  // digit count: highest non-zero digit, zero still takes one digit
  always_comb begin
    nd_c = LEN_W'(1);
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[i] != '0) nd_c = LEN_W'(i + 1);
    end
  end

  assign tot_c = nd_c + LEN_W'(neg_r);
  assign cnt_c = (tot_c > MAX_LEN) ? MAX_LEN : tot_c;

  always_ff @(posedge clk) begin
    if (do_load) begin
      bcd_r <= '0;
      if (in_tuser == CMD_S32 && low_c[HALF_W-1]) begin
        neg_r  <= 1'b1;
        mag_r  <= {HALF_W'(0) - low_c, {HALF_W{1'b0}}};
        iter_r <= ITER_W'(HALF_W);
      end else if (in_tuser == CMD_S32 || in_tuser == CMD_U32) begin
        neg_r  <= 1'b0;
        mag_r  <= {low_c, {HALF_W{1'b0}}};
        iter_r <= ITER_W'(HALF_W);
      end else begin
        neg_r  <= 1'b0;
        mag_r  <= in_tdata;
        iter_r <= ITER_W'(VALUE_W);
      end
    end else if (do_conv) begin
      bcd_r  <= bcd_step;
      mag_r  <= {mag_r[VALUE_W-2:0], 1'b0};
      iter_r <= iter_r - ITER_W'(1);
    end
    if (do_size) begin
      tot_r <= tot_c;
      cnt_r <= cnt_c;
      // drop leading characters beyond the limit
      pos_r <= tot_c - cnt_c;
    end else if (do_adv) begin
      pos_r <= pos_r + LEN_W'(1);
    end
  end

  // ---------------- character select ----------------
  assign last_c  = (pos_r == tot_r - LEN_W'(1));
  assign dig_idx = IDX_W'(tot_r - LEN_W'(1) - pos_r);
  assign char_c  = (neg_r && pos_r == '0) ? CHAR_MINUS
                                          : CHAR_ZERO + CHAR_W'(bcd_r[dig_idx]);

  assign out_tdata = {5'd0, cnt_r, char_c};
  assign out_tlast = last_c;

  // ---------------- assertions ----------------
  `ASSERT_IMPL(a_no_overlap, out_tvalid, !in_tready)
  `ASSERT_IMPL(a_char_range, out_tvalid,
               out_tdata[5:0] == CHAR_MINUS ||
               (out_tdata[5:0] >= CHAR_ZERO && out_tdata[5:0] <= CHAR_NINE))
  `ASSERT_NEXT(a_idle_after_last, out_tvalid && out_tready && out_tlast, in_tready)
  `ASSERT_NEXT(a_conv_after_load, in_tvalid && in_tready, !out_tvalid && !in_tready)

endmodule

// ----- tb/sv/int_to_decimal_ascii_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core_tb
// Self-checking bench for the integer to decimal ASCII converter. A queue of
// numbers (directed corner values, then random ones) feeds a clocked driver
// on in_. A clocked monitor on out_ checks every character, text length and
// last flag against the decimal text worked out here. Both sides idle at
// random, and once the receiver holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii_core_tb;
  import itda_pkg::*;

  localparam logic [CMD_W-1:0] CMD_U64     = 2'd2;
  localparam logic [CMD_W-1:0] CMD_U64_ALT = 2'd3;  // bit 1 set: read as 64-bit
  localparam logic [63:0]      RADIX       = 64'd10;
  localparam int               STALL_CYCLES = 400;
  localparam int               RANDOM_PER_PHASE = 100;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [63:0]      value;
  } number_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic [LEN_W-1:0]  len;
    logic              last;
  } char_due_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [63:0] value
  logic [1:0]  in_tuser = '0;   // [1:0] command
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [5:0] character, [10:6] text_length, zero pad
  logic        out_tlast;

  number_t   numbers_to_send[$];
  char_due_t text_due[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  stall_req = 1'b0;
  bit  stall_seen = 1'b0;
  int  hold_left = 0;
  int  mismatches = 0;
  int  numbers_taken = 0;
  int  negatives_taken = 0;
  int  chars_checked = 0;
  int  cmd_counts[4] = '{0, 0, 0, 0};

  int_to_decimal_ascii_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // Work out the decimal text of one number and queue its characters.
  task automatic queue_decimal_text(input logic [CMD_W-1:0] cmd, input logic [63:0] raw);
    logic [63:0]       mag;
    logic [63:0]       digit;
    logic [CHAR_W-1:0] text[$];
    bit                neg;
    int                first;
    int                count;
    char_due_t         c;
    neg = 1'b0;
    case (cmd)
      CMD_S32: begin
        if (raw[31]) begin
          neg = 1'b1;
          mag = {32'd0, 32'd0 - raw[31:0]};
        end else begin
          mag = {32'd0, raw[31:0]};
        end
      end
      CMD_U32: mag = {32'd0, raw[31:0]};
      default: mag = raw;
    endcase
    do begin
      digit = mag % RADIX;
      text.push_front(CHAR_ZERO + digit[CHAR_W-1:0]);
      mag = mag / RADIX;
    end while (mag != 0 && text.size() < NUM_DIGITS);
    if (neg) text.push_front(CHAR_MINUS);
    // keep only the least significant characters if the text is too long
    first = (text.size() > MAX_CHARS) ? text.size() - MAX_CHARS : 0;
    count = text.size() - first;
    for (int k = 0; k < count; k++) begin
      c.ch   = text[first + k];
      c.len  = count[LEN_W-1:0];
      c.last = (k == count - 1);
      text_due.push_back(c);
    end
    if (neg) negatives_taken++;
  endtask

  task automatic queue_number(input logic [CMD_W-1:0] cmd, input logic [63:0] value);
    number_t n;
    n.cmd   = cmd;
    n.value = value;
    numbers_to_send.push_back(n);
  endtask

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    logic [63:0] p;
    int          k;
    case ($urandom_range(0, 7))
      0: begin
        // power of ten or one below it
        p = 64'd1;
        k = $urandom_range(0, 19);
        repeat (k) p = p * RADIX;
        v = p - 64'($urandom_range(0, 1));
      end
      1: v = $urandom_range(0, 1) ? 64'd0 : '1;
      2: v = {$urandom, $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF};
      default: begin
        v = {$urandom, $urandom};
        v = v >> $urandom_range(0, 63);
        if ($urandom_range(0, 1)) v[63:32] = $urandom;
      end
    endcase
    return v;
  endfunction

  // Driver: predict on every accepted transaction, then offer the next number.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        queue_decimal_text(in_tuser, in_tdata);
        numbers_taken++;
        cmd_counts[in_tuser]++;
      end
      if (!in_tvalid || in_tready) begin
        if (numbers_to_send.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          number_t n;
          n = numbers_to_send.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= n.value;
          in_tuser  <= n.cmd;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: long hold-off on request, otherwise random back-pressure.
  always @(posedge clk) begin
    if (stall_req != stall_seen) begin
      stall_seen <= stall_req;
      hold_left  <= STALL_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Monitor: compare each character transaction with the oldest one due.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (text_due.size() == 0) begin
        report_mismatch($sformatf("unexpected character 0x%02h", out_tdata[5:0]));
      end else begin
        char_due_t c;
        c = text_due.pop_front();
        if (out_tdata[5:0] !== c.ch)
          report_mismatch($sformatf("character %0d, want %0d", out_tdata[5:0], c.ch));
        if (out_tdata[10:6] !== c.len)
          report_mismatch($sformatf("text_length %0d, want %0d", out_tdata[10:6], c.len));
        if (out_tlast !== c.last)
          report_mismatch($sformatf("last %0b, want %0b", out_tlast, c.last));
        chars_checked++;
      end
    end
  end

  task automatic drain();
    while (numbers_to_send.size() > 0 || in_tvalid || text_due.size() > 0) @(negedge clk);
  endtask

  task automatic queue_random(input int n);
    repeat (n) queue_number(CMD_W'($urandom_range(0, 3)), pick_value());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // phase one: sender idles a little, receiver a lot
    send_idle_pct = 26;
    recv_idle_pct = 81;
    queue_number(CMD_S32, 64'd0);
    queue_number(CMD_S32, 64'd1);
    queue_number(CMD_S32, 64'h0000_0000_FFFF_FFFF);
    queue_number(CMD_S32, 64'h0000_0000_8000_0000);
    queue_number(CMD_S32, 64'hFFFF_FFFF_7FFF_FFFF);
    queue_number(CMD_S32, 64'h1234_5678_FFFF_FFF6);
    queue_number(CMD_U32, 64'd0);
    queue_number(CMD_U32, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_number(CMD_U32, 64'h0000_0000_8000_0000);
    queue_number(CMD_U32, 64'd1_000_000_000);
    queue_number(CMD_U64, 64'd0);
    queue_number(CMD_U64, 64'd9);
    queue_number(CMD_U64, 64'd10);
    queue_number(CMD_U64, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_number(CMD_U64, 64'h8000_0000_0000_0000);
    queue_number(CMD_U64, 64'd10_000_000_000_000_000_000);
    queue_number(CMD_U64, 64'd9_999_999_999_999_999_999);
    queue_number(CMD_U64_ALT, 64'd0);
    queue_number(CMD_U64_ALT, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_number(CMD_U64_ALT, 64'h0000_0001_0000_0000);
    drain();
    queue_random(RANDOM_PER_PHASE);
    drain();

    // phase two: the other way round
    send_idle_pct = 81;
    recv_idle_pct = 26;
    queue_random(RANDOM_PER_PHASE);
    drain();

    // phase three: no idling, opening with a long receiver hold-off
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(RANDOM_PER_PHASE);
    stall_req = ~stall_req;
    drain();

    repeat (120) @(negedge clk);
    if (text_due.size() != 0)
      report_mismatch($sformatf("%0d characters never arrived", text_due.size()));

    $display("Converted %0d numbers (s32 %0d, u32 %0d, u64 %0d, cmd3 %0d; %0d negative)",
             numbers_taken, cmd_counts[0], cmd_counts[1], cmd_counts[2], cmd_counts[3],
             negatives_taken);
    $display("Checked %0d characters across three back-pressure profiles, %0d mismatches",
             chars_checked, mismatches);
    if (mismatches == 0) begin
      $display("PASS int_to_decimal_ascii_core");
    end else begin
      $display("FAIL int_to_decimal_ascii_core");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Timed out with %0d numbers unsent and %0d characters due",
             numbers_to_send.size(), text_due.size());
    $display("FAIL int_to_decimal_ascii_core");
    $finish;
  end

endmodule
